[src/sbd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sector block device package
// Shared constants, payload structs, command and state codes, and the
// request bundles that the controller sends to the two storage arrays.
// ----------------------------------------------------------------------------
package sbd_pkg;

  // Geometry. Both counts are powers of two, so a sector number is a mask of
  // the address and a store address is the sector and word concatenated.
  localparam int SECTOR_WORDS = 512;
  localparam int DISK_SECTORS = 64;

  localparam int WORD_AW   = (SECTOR_WORDS > 1) ? $clog2(SECTOR_WORDS) : 1;
  localparam int SECT_AW   = (DISK_SECTORS > 1) ? $clog2(DISK_SECTORS) : 1;
  localparam int DISK_AW   = SECT_AW + WORD_AW;
  localparam int DISK_DEPTH = 2 ** DISK_AW;
  localparam int CNT_W     = WORD_AW + 1;

  localparam int DATA_W = 16;
  localparam int ADDR_W = 16;
  localparam int TICK_W = 8;

  localparam logic [TICK_W-1:0] BUSY_TICKS_RESET = 8'd20;

  typedef enum logic [1:0] {
    CMD_RESET = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_NONE  = 2'd3
  } sbd_cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COPY,
    ST_WRITE,
    ST_COMMIT,
    ST_READ,
    ST_RDATA,
    ST_DONE
  } sbd_state_t;

  typedef struct packed {
    sbd_cmd_t           req_type;
    logic               start_req;
    logic [ADDR_W-1:0]  sector_address;
    logic [DATA_W-1:0]  write_word;
    logic               read_strobe;
    logic               write_strobe;
  } sbd_in_t;

  typedef struct packed {
    logic               busy_res;
    logic               ready_res;
    logic               io_ready;
    logic [DATA_W-1:0]  read_word;
  } sbd_out_t;

  typedef struct packed {
    logic                we;
    logic [WORD_AW-1:0]  waddr;
    logic [DATA_W-1:0]   wdata;
    logic                re;
    logic [WORD_AW-1:0]  raddr;
  } sbd_buf_req_t;

  typedef struct packed {
    logic                we;
    logic [DISK_AW-1:0]  waddr;
    logic [DATA_W-1:0]   wdata;
    logic                re;
    logic [DISK_AW-1:0]  raddr;
  } sbd_disk_req_t;

endpackage

[src/sbd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port, with registered read data.
// ----------------------------------------------------------------------------
module sbd_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/sbd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sector block device controller
// Sequences one sample at a time: start edge handling, sector copy from the
// store, buffer write and commit, buffer read, and the busy countdown.
// ----------------------------------------------------------------------------
module sbd_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [sbd_pkg::TICK_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sbd_pkg::sbd_in_t              in_data,
  input  logic                          slot_free,
  output logic                          res_valid,
  output sbd_pkg::sbd_out_t             res_data,
  output sbd_pkg::sbd_buf_req_t         buf_req,
  input  logic [sbd_pkg::DATA_W-1:0]    buf_rdata,
  output sbd_pkg::sbd_disk_req_t        disk_req,
  input  logic [sbd_pkg::DATA_W-1:0]    disk_rdata
);

  sbd_pkg::sbd_state_t state, state_next;
  sbd_pkg::sbd_in_t    item;

  logic [sbd_pkg::TICK_W-1:0]       busy_ticks;
  logic                             prev_start, prev_read;
  logic [sbd_pkg::SECT_AW-1:0]      cur_sector;
  logic [sbd_pkg::WORD_AW-1:0]      wi;
  logic [sbd_pkg::CNT_W-1:0]        ri;
  logic                             armed;
  logic [sbd_pkg::TICK_W-1:0]       busy_cd;
  logic                             busy_flag, ready_flag, read_pending;
  logic                             blocks_left;
  logic [sbd_pkg::DATA_W-1:0]       out_word;
  logic                             io_low;
  logic [sbd_pkg::DISK_SECTORS-1:0] sect_valid;
  logic [sbd_pkg::CNT_W-1:0]        cnt;
  logic                             pipe_v;
  logic [sbd_pkg::WORD_AW-1:0]      pipe_a;

  logic                             start_rise, rd_fall, copy_cmd;
  logic                             wr_commit, cnt_live, cd_end;
  logic [sbd_pkg::CNT_W-1:0]        buf_len, ri_step;
  logic [sbd_pkg::WORD_AW-1:0]      rd_pos;
  logic [sbd_pkg::SECT_AW-1:0]      sector_inc;
  sbd_pkg::sbd_state_t              first_state, after_copy, after_commit;

  // Decode of the sample being offered and of the one in progress.
  assign start_rise = in_data.start_req & ~prev_start;
  assign rd_fall    = ~in_data.read_strobe & prev_read;
  assign copy_cmd   = start_rise && (in_data.req_type == sbd_pkg::CMD_READ);

  assign wr_commit = !armed || (wi == sbd_pkg::WORD_AW'(sbd_pkg::SECTOR_WORDS - 1));
  assign cnt_live  = cnt < sbd_pkg::CNT_W'(sbd_pkg::SECTOR_WORDS);
  assign cd_end    = busy_cd == sbd_pkg::TICK_W'(1);

  assign buf_len = armed ? sbd_pkg::CNT_W'(sbd_pkg::SECTOR_WORDS) : '0;
  assign ri_step = (ri < buf_len) ? ri + sbd_pkg::CNT_W'(1) : ri;
  assign rd_pos  = (ri > sbd_pkg::CNT_W'(sbd_pkg::SECTOR_WORDS - 1))
                 ? sbd_pkg::WORD_AW'(sbd_pkg::SECTOR_WORDS - 1)
                 : ri[sbd_pkg::WORD_AW-1:0];

  assign sector_inc = (cur_sector == sbd_pkg::SECT_AW'(sbd_pkg::DISK_SECTORS - 1))
                    ? '0 : cur_sector + sbd_pkg::SECT_AW'(1);

  always_comb begin
    if (copy_cmd) begin
      first_state = sbd_pkg::ST_COPY;
    end else if (in_data.write_strobe) begin
      first_state = sbd_pkg::ST_WRITE;
    end else if (in_data.read_strobe) begin
      first_state = sbd_pkg::ST_READ;
    end else begin
      first_state = sbd_pkg::ST_DONE;
    end
  end

  assign after_commit = item.read_strobe ? sbd_pkg::ST_READ : sbd_pkg::ST_DONE;
  assign after_copy   = item.write_strobe ? sbd_pkg::ST_WRITE : after_commit;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      sbd_pkg::ST_CLEAR: begin
        if (cnt == sbd_pkg::CNT_W'(sbd_pkg::SECTOR_WORDS - 1)) begin
          state_next = sbd_pkg::ST_IDLE;
        end
      end
      sbd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = first_state;
        end
      end
      sbd_pkg::ST_COPY: begin
        if (!cnt_live) begin
          state_next = after_copy;
        end
      end
      sbd_pkg::ST_WRITE: begin
        state_next = wr_commit ? sbd_pkg::ST_COMMIT : after_commit;
      end
      sbd_pkg::ST_COMMIT: begin
        if (!cnt_live) begin
          state_next = after_commit;
        end
      end
      sbd_pkg::ST_READ:  state_next = sbd_pkg::ST_RDATA;
      sbd_pkg::ST_RDATA: state_next = sbd_pkg::ST_DONE;
      sbd_pkg::ST_DONE: begin
        if (slot_free) begin
          state_next = sbd_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // Memory requests and handshake outputs.
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    buf_req   = '0;
    disk_req  = '0;
    unique case (state)
      sbd_pkg::ST_CLEAR: begin
        buf_req.we    = 1'b1;
        buf_req.waddr = cnt[sbd_pkg::WORD_AW-1:0];
      end
      sbd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      sbd_pkg::ST_COPY: begin
        disk_req.re    = cnt_live;
        disk_req.raddr = {cur_sector, cnt[sbd_pkg::WORD_AW-1:0]};
        buf_req.we     = pipe_v;
        buf_req.waddr  = pipe_a;
        // A sector never committed since reset reads as zero.
        buf_req.wdata  = sect_valid[cur_sector] ? disk_rdata : '0;
      end
      sbd_pkg::ST_WRITE: begin
        buf_req.we    = 1'b1;
        buf_req.waddr = wi;
        buf_req.wdata = item.write_word;
      end
      sbd_pkg::ST_COMMIT: begin
        buf_req.re     = cnt_live;
        buf_req.raddr  = cnt[sbd_pkg::WORD_AW-1:0];
        disk_req.we    = pipe_v;
        disk_req.waddr = {cur_sector, pipe_a};
        disk_req.wdata = buf_rdata;
      end
      sbd_pkg::ST_READ: begin
        buf_req.re    = 1'b1;
        buf_req.raddr = rd_pos;
      end
      sbd_pkg::ST_RDATA: begin
      end
      sbd_pkg::ST_DONE: begin
        res_valid = slot_free;
      end
    endcase
  end

  // Result of the sample, with the countdown step folded in.
  always_comb begin
    res_data.busy_res  = cd_end ? 1'b0 : busy_flag;
    res_data.ready_res = cd_end ? 1'b1 : ready_flag;
    res_data.io_ready  = (cd_end && read_pending) ? 1'b1 : !io_low;
    res_data.read_word = out_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sbd_pkg::ST_CLEAR;
      cnt          <= '0;
      busy_ticks   <= sbd_pkg::BUSY_TICKS_RESET;
      prev_start   <= 1'b0;
      prev_read    <= 1'b0;
      cur_sector   <= '0;
      wi           <= '0;
      ri           <= '0;
      armed        <= 1'b0;
      busy_cd      <= '0;
      busy_flag    <= 1'b0;
      ready_flag   <= 1'b0;
      read_pending <= 1'b0;
      blocks_left  <= 1'b0;
      out_word     <= '0;
      io_low       <= 1'b0;
      sect_valid   <= '0;
      pipe_v       <= 1'b0;
    end else begin
      state  <= state_next;
      pipe_v <= 1'b0;
      if (cfg_wr_en) begin
        busy_ticks <= cfg_wr_data;
      end
      unique case (state)
        sbd_pkg::ST_CLEAR: begin
          cnt <= cnt + sbd_pkg::CNT_W'(1);
        end
        sbd_pkg::ST_IDLE: begin
          if (in_valid) begin
            item       <= in_data;
            prev_start <= in_data.start_req;
            prev_read  <= in_data.read_strobe;
            io_low     <= rd_fall;
            cnt        <= '0;
            if (start_rise) begin
              ready_flag <= 1'b0;
              busy_flag  <= 1'b1;
              out_word   <= '0;
              cur_sector <= in_data.sector_address[sbd_pkg::SECT_AW-1:0];
              unique case (in_data.req_type)
                sbd_pkg::CMD_RESET: begin
                  busy_cd <= busy_ticks;
                end
                sbd_pkg::CMD_READ: begin
                  armed        <= 1'b1;
                  ri           <= '0;
                  wi           <= '0;
                  busy_cd      <= busy_ticks;
                  read_pending <= 1'b1;
                end
                sbd_pkg::CMD_WRITE: begin
                  armed       <= 1'b1;
                  ri          <= '0;
                  wi          <= '0;
                  busy_cd     <= busy_ticks;
                  blocks_left <= 1'b1;
                end
                sbd_pkg::CMD_NONE: begin
                end
              endcase
            end
          end
        end
        sbd_pkg::ST_COPY: begin
          if (cnt_live) begin
            cnt    <= cnt + sbd_pkg::CNT_W'(1);
            pipe_v <= 1'b1;
            pipe_a <= cnt[sbd_pkg::WORD_AW-1:0];
          end
        end
        sbd_pkg::ST_WRITE: begin
          cnt <= '0;
          wi  <= wr_commit ? '0 : wi + sbd_pkg::WORD_AW'(1);
        end
        sbd_pkg::ST_COMMIT: begin
          if (cnt_live) begin
            cnt    <= cnt + sbd_pkg::CNT_W'(1);
            pipe_v <= 1'b1;
            pipe_a <= cnt[sbd_pkg::WORD_AW-1:0];
          end else begin
            sect_valid[cur_sector] <= 1'b1;
            cur_sector             <= sector_inc;
            if (blocks_left) begin
              blocks_left <= 1'b0;
              ready_flag  <= 1'b1;
            end
          end
        end
        sbd_pkg::ST_READ: begin
          ri <= ri_step;
          if (ri_step >= buf_len) begin
            io_low <= 1'b1;
          end
        end
        sbd_pkg::ST_RDATA: begin
          out_word <= buf_rdata;
        end
        sbd_pkg::ST_DONE: begin
          if (slot_free) begin
            if (busy_cd != '0) begin
              busy_cd <= busy_cd - sbd_pkg::TICK_W'(1);
            end
            if (cd_end) begin
              busy_flag    <= 1'b0;
              ready_flag   <= 1'b1;
              read_pending <= 1'b0;
            end
          end
        end
      endcase
    end
  end

  // The buffer and the store are never both written in one cycle.
  a_single_writer: assert property (@(posedge clk) disable iff (rst)
    !(buf_req.we && disk_req.we))
    else $error("buffer and store written in the same cycle");

  // The read index never passes the end of the sector.
  a_read_index: assert property (@(posedge clk) disable iff (rst)
    ri <= sbd_pkg::CNT_W'(sbd_pkg::SECTOR_WORDS))
    else $error("read index past sector end");

  // A commit leaves only after walking the whole sector.
  a_commit_len: assert property (@(posedge clk) disable iff (rst)
    (state == sbd_pkg::ST_COMMIT && state_next != sbd_pkg::ST_COMMIT)
      |-> cnt == sbd_pkg::CNT_W'(sbd_pkg::SECTOR_WORDS))
    else $error("commit ended early");

  // The copy pipe only carries data launched by a copy or a commit walk.
  a_pipe_src: assert property (@(posedge clk) disable iff (rst)
    pipe_v |-> ($past(state) == sbd_pkg::ST_COPY || $past(state) == sbd_pkg::ST_COMMIT))
    else $error("pipe valid outside a sector walk");

  // Busy only drops when the countdown runs out.
  a_busy_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(busy_flag) |-> busy_cd == '0)
    else $error("busy dropped with countdown running");

endmodule

[src/sector_block_device_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sector block device top level
// One sample of a sector disk interface per input transfer, one status result
// per sample, with a 512-word sector buffer and a 64-sector backing store.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                          | Direction | Notes
//  ---------+----------------------------------+-----------+------------------
//  input    | in_valid, in_ready, in_data      | in        | one sample
//  output   | out_valid, out_ready, out_data   | out       | one result
//  config   | cfg_wr_en, cfg_wr_data           | in        | busy_ticks
//
// A sample passes through the idle and done states, and also through the write
// state when the write strobe is high and the read and read-data states when
// the read strobe is high. A read command start adds a walk that copies the
// sector out of the store, and a full write buffer adds a walk that commits it;
// both walks move one word per cycle through the source array's single read port.
// After reset, a clearing pass zeroes the sector buffer before the
// first input transfer is taken; store sectors read as zero until committed.
// The next input transfer is taken while a finished result is still waiting
// in the output register.
//
module sector_block_device_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [sbd_pkg::TICK_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sbd_pkg::sbd_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sbd_pkg::sbd_out_t             out_data
);

  sbd_pkg::sbd_buf_req_t  buf_req;
  sbd_pkg::sbd_disk_req_t disk_req;
  sbd_pkg::sbd_out_t      res_data;
  logic [sbd_pkg::DATA_W-1:0] buf_rdata;
  logic [sbd_pkg::DATA_W-1:0] disk_rdata;
  logic                   res_valid;
  logic                   slot_free;

  // The output register can take a new result when it is empty or when its
  // current result leaves in this cycle.
  assign slot_free = !out_valid || out_ready;

  sbd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .slot_free   (slot_free),
    .res_valid   (res_valid),
    .res_data    (res_data),
    .buf_req     (buf_req),
    .buf_rdata   (buf_rdata),
    .disk_req    (disk_req),
    .disk_rdata  (disk_rdata)
  );

  // Sector buffer: one sector of words, streamed and walked by the controller.
  sbd_ram #(
    .DEPTH (sbd_pkg::SECTOR_WORDS),
    .WIDTH (sbd_pkg::DATA_W),
    .AW    (sbd_pkg::WORD_AW)
  ) u_buf (
    .clk   (clk),
    .we    (buf_req.we),
    .waddr (buf_req.waddr),
    .wdata (buf_req.wdata),
    .re    (buf_req.re),
    .raddr (buf_req.raddr),
    .rdata (buf_rdata)
  );

  // Backing store: all sectors, addressed as sector and word.
  sbd_ram #(
    .DEPTH (sbd_pkg::DISK_DEPTH),
    .WIDTH (sbd_pkg::DATA_W),
    .AW    (sbd_pkg::DISK_AW)
  ) u_disk (
    .clk   (clk),
    .we    (disk_req.we),
    .waddr (disk_req.waddr),
    .wdata (disk_req.wdata),
    .re    (disk_req.re),
    .raddr (disk_req.raddr),
    .rdata (disk_rdata)
  );

  // Output register. The result is held until the output transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data <= res_data;
    end
  end

endmodule

[tb/sbd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sector block device checker
// Follows every sample and result transfer, keeps its own copy of the device
// state, and checks each status result against the predicted one in order.
// ----------------------------------------------------------------------------
module sbd_checker
  import sbd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [TICK_W-1:0]  cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  sbd_in_t            in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  sbd_out_t           out_data,
  output int                 fail_count,
  output int                 pending
);

  logic [TICK_W-1:0]  busy_ticks;
  logic               prev_start_q, prev_rd_q, prev_wr_q;
  logic [SECT_AW-1:0] cur_sector;
  logic [CNT_W-1:0]   wr_idx, rd_idx, buf_len;
  logic [TICK_W-1:0]  countdown;
  logic               busy_q, ready_q, rd_pending, wr_active, rd_active;
  logic [7:0]         blocks_left;
  logic [DATA_W-1:0]  last_word;
  logic [DATA_W-1:0]  sec_buf [SECTOR_WORDS];
  logic [DATA_W-1:0]  store_mem [DISK_DEPTH];

  sbd_out_t status_queue [$];
  sbd_out_t want;
  int       errors = 0;

  task automatic clear_device();
    busy_ticks   = BUSY_TICKS_RESET;
    prev_start_q = 1'b0;
    prev_rd_q    = 1'b0;
    prev_wr_q    = 1'b0;
    cur_sector   = '0;
    wr_idx       = '0;
    rd_idx       = '0;
    buf_len      = '0;
    countdown    = '0;
    busy_q       = 1'b0;
    ready_q      = 1'b0;
    rd_pending   = 1'b0;
    wr_active    = 1'b0;
    rd_active    = 1'b0;
    blocks_left  = '0;
    last_word    = '0;
    for (int k = 0; k < SECTOR_WORDS; k++) sec_buf[k] = '0;
    for (int k = 0; k < DISK_DEPTH; k++) store_mem[k] = '0;
  endtask

  // Advance the device by one sample and return the status it reports.
  function automatic sbd_out_t step_device(sbd_in_t s);
    logic     start_rise, rd_rise, rd_fall, wr_rise, wr_fall, io;
    int       base, pos;
    sbd_out_t r;
    start_rise   = s.start_req && !prev_start_q;
    rd_rise      = s.read_strobe && !prev_rd_q;
    rd_fall      = !s.read_strobe && prev_rd_q;
    wr_rise      = s.write_strobe && !prev_wr_q;
    wr_fall      = !s.write_strobe && prev_wr_q;
    io           = 1'b1;
    prev_start_q = s.start_req;
    prev_rd_q    = s.read_strobe;
    prev_wr_q    = s.write_strobe;

    if (start_rise) begin
      ready_q    = 1'b0;
      busy_q     = 1'b1;
      last_word  = '0;
      cur_sector = SECT_AW'(s.sector_address % DISK_SECTORS);
      case (s.req_type)
        CMD_RESET: begin
          countdown = busy_ticks;
        end
        CMD_READ: begin
          base = int'(cur_sector) * SECTOR_WORDS;
          for (int k = 0; k < SECTOR_WORDS; k++) sec_buf[k] = store_mem[base + k];
          buf_len    = CNT_W'(SECTOR_WORDS);
          rd_idx     = '0;
          wr_idx     = '0;
          countdown  = busy_ticks;
          rd_pending = 1'b1;
        end
        CMD_WRITE: begin
          buf_len     = CNT_W'(SECTOR_WORDS);
          rd_idx      = '0;
          wr_idx      = '0;
          countdown   = busy_ticks;
          blocks_left = 8'd1;
        end
        default: begin
        end
      endcase
    end

    if (wr_rise) wr_active = 1'b1;
    if (wr_fall) wr_active = 1'b0;

    if (s.write_strobe && wr_active) begin
      if (wr_idx < SECTOR_WORDS) sec_buf[wr_idx[WORD_AW-1:0]] = s.write_word;
      if (wr_idx < buf_len) wr_idx = wr_idx + 1'b1;
      // An unarmed buffer has length zero, so every word commits at once.
      if (wr_idx >= buf_len) begin
        base = int'(cur_sector) * SECTOR_WORDS;
        for (int k = 0; k < SECTOR_WORDS; k++) store_mem[base + k] = sec_buf[k];
        wr_idx     = '0;
        cur_sector = cur_sector + 1'b1;
        if (blocks_left != 0) begin
          blocks_left = blocks_left - 1'b1;
          if (blocks_left == 0) ready_q = 1'b1;
        end
      end
    end

    if (rd_rise) rd_active = 1'b1;
    if (rd_fall) begin
      rd_active = 1'b0;
      io        = 1'b0;
    end

    if (s.read_strobe && rd_active) begin
      // Past the end of the sector the last word keeps coming back.
      pos       = (rd_idx > SECTOR_WORDS - 1) ? SECTOR_WORDS - 1 : int'(rd_idx);
      last_word = sec_buf[pos];
      if (rd_idx < buf_len) rd_idx = rd_idx + 1'b1;
      if (rd_idx >= buf_len) io = 1'b0;
    end

    if (countdown != 0) begin
      countdown = countdown - 1'b1;
      if (countdown == 0) begin
        busy_q  = 1'b0;
        ready_q = 1'b1;
        if (rd_pending) begin
          rd_pending = 1'b0;
          io         = 1'b1;
        end
      end
    end

    r.busy_res  = busy_q;
    r.ready_res = ready_q;
    r.io_ready  = io;
    r.read_word = last_word;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_device();
      status_queue.delete();
    end else begin
      if (cfg_wr_en) busy_ticks = cfg_wr_data;

      // Results are checked before the new sample is queued, since a result
      // can never belong to a sample taken at the same edge.
      if (out_valid && out_ready) begin
        if (status_queue.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: unexpected result busy=%0b ready=%0b io=%0b word=%h", $realtime,
                     out_data.busy_res, out_data.ready_res, out_data.io_ready,
                     out_data.read_word);
          end
        end else begin
          want = status_queue.pop_front();
          if (out_data.busy_res !== want.busy_res || out_data.ready_res !== want.ready_res ||
              out_data.io_ready !== want.io_ready || out_data.read_word !== want.read_word) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch expected busy=%0b ready=%0b io=%0b word=%h", $realtime,
                       want.busy_res, want.ready_res, want.io_ready, want.read_word);
              $display("%0t:          actual   busy=%0b ready=%0b io=%0b word=%h", $realtime,
                       out_data.busy_res, out_data.ready_res, out_data.io_ready,
                       out_data.read_word);
            end
          end
        end
      end

      if (in_valid && in_ready) status_queue.push_back(step_device(in_data));
    end
    fail_count <= errors;
    pending    <= status_queue.size();
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sector block device testbench
// Drives samples of the disk interface with random gaps and output stalls, and
// lets a checker beside the device predict and compare every status result.
// ----------------------------------------------------------------------------
module tb_top;
  import sbd_pkg::*;

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [TICK_W-1:0]  cfg_wr_data;
  logic               in_valid;
  logic               in_ready;
  sbd_in_t            in_data;
  logic               out_valid;
  logic               out_ready;
  sbd_out_t           out_data;
  int                 fail_count;
  int                 pending;

  // Stimulus bookkeeping. The start level is remembered so that a command
  // pulse always produces a clean rising edge, and the last write address is
  // reused for reads so that committed sectors get read back.
  int                 items_sent = 0;
  logic               last_start = 1'b0;
  logic [ADDR_W-1:0]  write_addr = '0;
  bit                 no_idle = 1'b0;
  int                 stall_left = 0;

  sector_block_device_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  sbd_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Idle lengths: mostly none, some short, now and then a long one.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // The receiving side stalls on its own schedule. Ready is not tied to valid,
  // so stalls fall on every phase of the device's work, including the long
  // sector copies and commits.
  always @(posedge clk) begin
    if (stall_left == 0 && !no_idle) stall_left = idle_len();
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Fully random sample; callers override the fields that shape a sequence.
  function automatic sbd_in_t rand_sample();
    sbd_in_t s;
    s.req_type       = sbd_cmd_t'($urandom_range(0, 3));
    s.start_req      = 1'($urandom_range(0, 1));
    s.sector_address = ADDR_W'($urandom);
    s.write_word     = DATA_W'($urandom);
    s.read_strobe    = 1'($urandom_range(0, 1));
    s.write_strobe   = 1'($urandom_range(0, 1));
    return s;
  endfunction

  // One sample transfer. Valid may drop for a random gap first; once raised it
  // holds with the same payload until the device takes it. The task returns
  // at the accepting edge with valid still high.
  task automatic send_sample(sbd_in_t s);
    int gap;
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    last_start = s.start_req;
  endtask

  task automatic drive_sample(sbd_cmd_t c, logic st, logic [ADDR_W-1:0] a,
                              logic [DATA_W-1:0] w, logic rd, logic wr);
    sbd_in_t s;
    s.req_type       = c;
    s.start_req      = st;
    s.sector_address = a;
    s.write_word     = w;
    s.read_strobe    = rd;
    s.write_strobe   = wr;
    send_sample(s);
  endtask

  // A command is a one-sample start pulse with both strobes low. If start was
  // left high by noise, it is dropped first so the pulse has a rising edge.
  task automatic pulse_command(sbd_cmd_t c, logic [ADDR_W-1:0] a);
    if (last_start) drive_sample(CMD_NONE, 1'b0, '0, DATA_W'($urandom), 1'b0, 1'b0);
    drive_sample(c, 1'b1, a, DATA_W'($urandom), 1'b0, 1'b0);
    drive_sample(sbd_cmd_t'($urandom_range(0, 3)), 1'b0, ADDR_W'($urandom),
                 DATA_W'($urandom), 1'b0, 1'b0);
  endtask

  // Streams count strobed samples with the given strobes high, split into
  // bursts separated by a sample with both strobes low. Indexes carry across
  // the bursts, so a write stream of a full sector still commits even when it
  // is broken up.
  task automatic stream_words(bit rd_on, bit wr_on, int count);
    sbd_in_t s;
    int      burst;
    while (count > 0) begin
      burst = ($urandom_range(0, 9) < 7) ? count : $urandom_range(1, count);
      count -= burst;
      repeat (burst) begin
        s              = rand_sample();
        s.start_req    = last_start;
        s.read_strobe  = rd_on;
        s.write_strobe = wr_on;
        send_sample(s);
      end
      s              = rand_sample();
      s.start_req    = last_start;
      s.read_strobe  = 1'b0;
      s.write_strobe = 1'b0;
      send_sample(s);
    end
  endtask

  // Random traffic: mostly short command sequences (write part of a sector,
  // read one back) with random content, the rest stray commands and noise.
  task automatic run_traffic(int quota);
    int stop_at, roll, n;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        write_addr = ADDR_W'($urandom);
        pulse_command(CMD_WRITE, write_addr);
        n = $urandom_range(1, 60);
        stream_words(1'b0, 1'b1, n);
      end else if (roll < 60) begin
        pulse_command(CMD_READ, ($urandom_range(0, 1) == 0) ? write_addr : ADDR_W'($urandom));
        n = $urandom_range(1, 60);
        stream_words(1'b1, 1'b0, n);
      end else if (roll < 75) begin
        pulse_command(sbd_cmd_t'($urandom_range(0, 3)), ADDR_W'($urandom));
      end else begin
        repeat ($urandom_range(1, 8)) send_sample(rand_sample());
      end
    end
  endtask

  // The register is to be written only while the device is idle; neither this task nor the device enforces that.
  task automatic set_busy_ticks(logic [TICK_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Stop sending and wait until every predicted result has come back. The
  // first edge lets the checker count the sample taken at the last edge.
  task automatic finish_phase();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    out_ready   <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part, run with a short countdown so that command ends, restarts
    // during a countdown and the forced io_ready of a read all show up.
    set_busy_ticks(8'd3);
    // Reads before any command: the buffer is unarmed, word 0 comes back and
    // io_ready is low; the falling strobe also drops io_ready.
    drive_sample(CMD_NONE, 1'b0, '0, '0, 1'b1, 1'b0);
    drive_sample(CMD_NONE, 1'b0, '0, '0, 1'b1, 1'b0);
    drive_sample(CMD_NONE, 1'b0, '0, '0, 1'b0, 1'b0);
    // Writes before any command: each word commits the whole buffer at once
    // and moves to the next sector, without raising ready.
    drive_sample(CMD_NONE, 1'b0, '0, 16'hFFFF, 1'b0, 1'b1);
    drive_sample(CMD_NONE, 1'b0, '0, 16'h0001, 1'b0, 1'b1);
    drive_sample(CMD_NONE, 1'b0, '0, '0, 1'b0, 1'b0);
    // Command none at the highest address: busy rises but no countdown runs.
    drive_sample(CMD_NONE, 1'b1, 16'hFFFF, '0, 1'b0, 1'b0);
    drive_sample(CMD_NONE, 1'b0, '0, '0, 1'b0, 1'b0);
    // Reset command, then a write and a read each restarting the countdown.
    drive_sample(CMD_RESET, 1'b1, 16'h0000, '0, 1'b0, 1'b0);
    drive_sample(CMD_NONE, 1'b0, '0, '0, 1'b0, 1'b0);
    drive_sample(CMD_WRITE, 1'b1, 16'h0041, '0, 1'b0, 1'b0);
    drive_sample(CMD_NONE, 1'b0, '0, 16'hA5A5, 1'b0, 1'b1);
    drive_sample(CMD_READ, 1'b1, 16'h0001, '0, 1'b0, 1'b0);
    // Read back the sector written before any command, then both strobes.
    drive_sample(CMD_NONE, 1'b0, '0, '0, 1'b1, 1'b0);
    drive_sample(CMD_NONE, 1'b0, '0, '0, 1'b1, 1'b0);
    drive_sample(CMD_NONE, 1'b0, '0, 16'h0000, 1'b1, 1'b1);
    drive_sample(CMD_NONE, 1'b0, '0, '0, 1'b1, 1'b0);
    drive_sample(CMD_NONE, 1'b0, '0, '0, 1'b0, 1'b0);
    drive_sample(CMD_WRITE, 1'b1, 16'h8000, 16'hFFFF, 1'b0, 1'b0);
    drive_sample(CMD_NONE, 1'b0, '0, '0, 1'b0, 1'b0);
    finish_phase();

    // Shortest countdown. The phase opens with a write command followed by a
    // stream with both strobes high: the full sector commits and raises ready,
    // and the reads of the same samples run past the end of the sector.
    set_busy_ticks(8'd1);
    write_addr = ADDR_W'($urandom);
    pulse_command(CMD_WRITE, write_addr);
    stream_words(1'b1, 1'b1, $urandom_range(513, 520));
    run_traffic(40);
    finish_phase();

    // Longest countdown.
    set_busy_ticks(8'd255);
    run_traffic(40);
    finish_phase();

    // A zero countdown never ends, so busy stays up; this phase also runs
    // with no gaps and no stalls on either side.
    no_idle = 1'b1;
    set_busy_ticks(8'd0);
    run_traffic(40);
    finish_phase();
    no_idle = 1'b0;

    set_busy_ticks(TICK_W'($urandom_range(2, 40)));
    run_traffic(40);
    finish_phase();

    // Give a stray late result the chance to show up before the verdict.
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, including the clearing
  // pass after reset and the sector copies and commits.
  initial begin
    #(50_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[files.f]
src/sbd_pkg.sv
src/sbd_ram.sv
src/sbd_ctrl.sv
src/sector_block_device_top.sv
tb/sbd_checker.sv
tb/tb_top.sv
